FILE: hdl/sts_pkg.sv
package sts_pkg;

   // field widths
   localparam int CHAR_W  = 16;
   localparam int VOICE_W = 4;
   localparam int VSET_W  = 2;
   localparam int SCOPE_W = 2;

   // default depth of the result queue (at least 2)
   localparam int OUTQ_DEPTH = 4;

   // result kinds
   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // character codes used by the parser
   localparam logic [CHAR_W-1:0] CH_BANG       = 16'h0021;
   localparam logic [CHAR_W-1:0] CH_QUOTE      = 16'h0022;
   localparam logic [CHAR_W-1:0] CH_ZERO       = 16'h0030;
   localparam logic [CHAR_W-1:0] CH_ONE        = 16'h0031;
   localparam logic [CHAR_W-1:0] CH_NINE       = 16'h0039;
   localparam logic [CHAR_W-1:0] CH_QMARK      = 16'h003F;
   localparam logic [CHAR_W-1:0] CH_UPPER_A    = 16'h0041;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 16'h005A;
   localparam logic [CHAR_W-1:0] CH_LBRACKET   = 16'h005B;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH  = 16'h005C;
   localparam logic [CHAR_W-1:0] CH_RBRACKET   = 16'h005D;
   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 16'h005F;
   localparam logic [CHAR_W-1:0] CH_LOWER_A    = 16'h0061;
   localparam logic [CHAR_W-1:0] CH_LOWER_H    = 16'h0068;
   localparam logic [CHAR_W-1:0] CH_LOWER_P    = 16'h0070;
   localparam logic [CHAR_W-1:0] CH_LOWER_Q    = 16'h0071;
   localparam logic [CHAR_W-1:0] CH_LOWER_S    = 16'h0073;
   localparam logic [CHAR_W-1:0] CH_LOWER_U    = 16'h0075;
   localparam logic [CHAR_W-1:0] CH_LOWER_W    = 16'h0077;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 16'h007A;

   // scope codes
   localparam logic [SCOPE_W-1:0] SCOPE_FIRST  = 2'd0;
   localparam logic [SCOPE_W-1:0] SCOPE_SECOND = 2'd1;
   localparam logic [SCOPE_W-1:0] SCOPE_OTHER  = 2'd2;

   // quick section close progress
   localparam logic [1:0] QCM_IDLE  = 2'd0;
   localparam logic [1:0] QCM_BSL   = 2'd1;
   localparam logic [1:0] QCM_USC   = 2'd2;

   // voice set codes
   localparam logic [VSET_W-1:0] VSET_FEMALE  = 2'd0;
   localparam logic [VSET_W-1:0] VSET_MALE    = 2'd1;

   // voice numbers
   localparam logic [VOICE_W-1:0] VOICE_F0    = 4'd1;
   localparam logic [VOICE_W-1:0] VOICE_F1    = 4'd2;
   localparam logic [VOICE_W-1:0] VOICE_M0    = 4'd3;
   localparam logic [VOICE_W-1:0] VOICE_M1    = 4'd4;
   localparam logic [VOICE_W-1:0] VOICE_OTHER = 4'd5;
   localparam logic [VOICE_W-1:0] VOICE_X0    = 4'd7;
   localparam logic [VOICE_W-1:0] VOICE_X1    = 4'd8;

   // parser modes
   typedef enum logic [3:0] {
      MODE_TEXT   = 4'd0,
      MODE_BSL    = 4'd1,
      MODE_USC    = 4'd2,
      MODE_AFTER  = 4'd3,
      MODE_BRK    = 4'd4,
      MODE_BQUO   = 4'd5,
      MODE_PSEL   = 4'd6,
      MODE_PNUM   = 4'd7,
      MODE_PSKIP  = 4'd8,
      MODE_QUICK  = 4'd9,
      MODE_QPSEL  = 4'd10,
      MODE_QPNUM  = 4'd11,
      MODE_QPSKIP = 4'd12
   } mode_type;

   // one result item
   typedef struct packed {
      logic               kind;
      logic [CHAR_W-1:0]  text_char;
      logic [VOICE_W-1:0] voice;
      logic               last_of_run;
   } result_type;

   // parser to queue: up to two results per step
   typedef struct packed {
      logic       push0;
      logic       push1;
      result_type res0;
      result_type res1;
   } push_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // digit value clamped to the scope range
   function automatic logic [SCOPE_W-1:0] digit_scope(input logic [CHAR_W-1:0] c);
      return (c[3:0] >= 4'd2) ? SCOPE_OTHER : c[SCOPE_W-1:0];
   endfunction

   function automatic logic is_tag_letter(input logic [CHAR_W-1:0] c);
      return is_digit(c)
         || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z))
         || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z))
         || (c == CH_BANG) || (c == CH_QMARK);
   endfunction

   function automatic logic [VOICE_W-1:0] voice_of(input logic [VSET_W-1:0] vs,
                                                   input logic [SCOPE_W-1:0] s);
      logic [VOICE_W-1:0] v;
      v = VOICE_OTHER;
      if (s == SCOPE_FIRST) begin
         v = (vs == VSET_FEMALE) ? VOICE_F0 : ((vs == VSET_MALE) ? VOICE_M0 : VOICE_X0);
      end else if (s == SCOPE_SECOND) begin
         v = (vs == VSET_FEMALE) ? VOICE_F1 : ((vs == VSET_MALE) ? VOICE_M1 : VOICE_X1);
      end
      return v;
   endfunction

   function automatic result_type make_result(input logic k,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [VOICE_W-1:0] v);
      result_type r;
      r.kind        = k;
      r.text_char   = ch;
      r.voice       = v;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

FILE: hdl/sts_if.sv
// input item channel
interface sts_req_if;
   logic                        valid;
   logic                        ready;
   logic [sts_pkg::CHAR_W-1:0]  char_code;
   logic                        end_of_script;

   modport source (output valid, output char_code, output end_of_script, input ready);
   modport sink   (input valid, input char_code, input end_of_script, output ready);
endinterface

// result item channel
interface sts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [sts_pkg::CHAR_W-1:0]  text_char;
   logic [sts_pkg::VOICE_W-1:0] voice;
   logic                        last_of_run;

   modport source (output valid, output kind, output text_char, output voice,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input text_char, input voice,
                   input last_of_run, output ready);
endinterface

FILE: hdl/sts_parser.sv
module sts_parser (
   input  logic                        clock,
   input  logic                        reset,
   sts_req_if.sink                     req,
   input  logic [sts_pkg::VSET_W-1:0]  voice_set,
   input  logic                        room,
   output sts_pkg::push_type           push
);

   // input register
   logic                        in_vld_ff, in_vld_in;
   logic [sts_pkg::CHAR_W-1:0]  in_char_ff;
   logic                        in_eos_ff;

   // parse state
   sts_pkg::mode_type           mode_ff, mode_in;
   logic [1:0]                  usc_ff, usc_in;
   logic                        dtf_ff, dtf_in;
   logic [1:0]                  qcm_ff, qcm_in;
   logic [sts_pkg::SCOPE_W-1:0] scope_ff, scope_in;
   logic [sts_pkg::SCOPE_W-1:0] pend_ff, pend_in;
   logic                        seg_text_ff, seg_text_in;

   logic                        req_fire;
   logic                        step_fire;
   logic                        body_vld, eos_vld;
   sts_pkg::result_type         body_res, eos_res;

   assign step_fire = in_vld_ff & room;
   assign req.ready = ~in_vld_ff | room;
   assign req_fire  = req.valid & req.ready;
   assign in_vld_in = req_fire | (in_vld_ff & ~step_fire);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_fire) begin
         in_char_ff <= req.char_code;
         in_eos_ff  <= req.end_of_script;
      end
   end

   // parse state register, advanced once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= sts_pkg::MODE_TEXT;
         usc_ff      <= '0;
         dtf_ff      <= 1'b0;
         qcm_ff      <= sts_pkg::QCM_IDLE;
         scope_ff    <= sts_pkg::SCOPE_FIRST;
         pend_ff     <= sts_pkg::SCOPE_FIRST;
         seg_text_ff <= 1'b0;
      end else if (step_fire) begin
         mode_ff     <= mode_in;
         usc_ff      <= usc_in;
         dtf_ff      <= dtf_in;
         qcm_ff      <= qcm_in;
         scope_ff    <= scope_in;
         pend_ff     <= pend_in;
         seg_text_ff <= seg_text_in;
      end
   end

   // one character step; the body emits at most one result, end of script one more
   always_comb begin
      logic                        do_text;
      logic                        do_quick;
      logic                        do_tag;
      logic                        do_psel;
      logic                        do_pnum;
      logic                        reading;
      logic                        quick;
      logic [sts_pkg::CHAR_W-1:0]  c;

      c           = in_char_ff;
      mode_in     = mode_ff;
      usc_in      = usc_ff;
      dtf_in      = dtf_ff;
      qcm_in      = qcm_ff;
      scope_in    = scope_ff;
      pend_in     = pend_ff;
      seg_text_in = seg_text_ff;
      body_vld    = 1'b0;
      body_res    = '0;
      eos_vld     = 1'b0;
      eos_res     = '0;
      do_text     = 1'b0;
      do_quick    = 1'b0;
      do_tag      = 1'b0;
      do_psel     = 1'b0;
      do_pnum     = 1'b0;
      reading     = 1'b0;
      quick       = 1'b0;

      unique case (mode_ff)
         sts_pkg::MODE_TEXT: do_text = 1'b1;
         sts_pkg::MODE_BSL: begin
            if (c == sts_pkg::CH_BACKSLASH) begin
               // escaped backslash
               body_vld    = 1'b1;
               body_res    = sts_pkg::make_result(sts_pkg::KIND_TEXT, c,
                                sts_pkg::voice_of(voice_set, scope_in));
               seg_text_in = 1'b1;
               mode_in     = sts_pkg::MODE_TEXT;
            end else if (c == sts_pkg::CH_ZERO || c == sts_pkg::CH_LOWER_H ||
                         c == sts_pkg::CH_ONE  || c == sts_pkg::CH_LOWER_U ||
                         c == sts_pkg::CH_LOWER_P) begin
               // scope tag closes the segment
               if (seg_text_in) begin
                  body_vld = 1'b1;
                  body_res = sts_pkg::make_result(sts_pkg::KIND_END, '0,
                                sts_pkg::voice_of(voice_set, scope_in));
               end
               seg_text_in = 1'b0;
               if (c == sts_pkg::CH_LOWER_P) begin
                  mode_in = sts_pkg::MODE_PSEL;
               end else begin
                  scope_in = (c == sts_pkg::CH_ONE || c == sts_pkg::CH_LOWER_U) ?
                             sts_pkg::SCOPE_SECOND : sts_pkg::SCOPE_FIRST;
                  mode_in  = sts_pkg::MODE_TEXT;
               end
            end else if (c == sts_pkg::CH_UNDERSCORE) begin
               usc_in  = 2'd1;
               mode_in = sts_pkg::MODE_USC;
            end else begin
               usc_in = 2'd0;
               do_tag = 1'b1;
            end
         end
         sts_pkg::MODE_USC: begin
            if (c == sts_pkg::CH_UNDERSCORE) begin
               if (usc_in < 2'd2) usc_in = usc_in + 2'd1;
            end else begin
               do_tag = 1'b1;
            end
         end
         sts_pkg::MODE_AFTER: begin
            if (c == sts_pkg::CH_LBRACKET) begin
               mode_in = sts_pkg::MODE_BRK;
            end else if (sts_pkg::is_digit(c) && dtf_in) begin
               mode_in = sts_pkg::MODE_TEXT;
            end else begin
               do_text = 1'b1;
            end
            dtf_in = 1'b0;
         end
         sts_pkg::MODE_BRK: begin
            if (c == sts_pkg::CH_QUOTE) mode_in = sts_pkg::MODE_BQUO;
            else if (c == sts_pkg::CH_RBRACKET) mode_in = sts_pkg::MODE_TEXT;
         end
         sts_pkg::MODE_BQUO: begin
            if (c == sts_pkg::CH_QUOTE) mode_in = sts_pkg::MODE_BRK;
         end
         sts_pkg::MODE_PSEL:   do_psel = 1'b1;
         sts_pkg::MODE_PNUM: begin
            do_pnum = 1'b1;
            reading = 1'b1;
         end
         sts_pkg::MODE_PSKIP:  do_pnum = 1'b1;
         sts_pkg::MODE_QUICK:  do_quick = 1'b1;
         sts_pkg::MODE_QPSEL: begin
            do_psel = 1'b1;
            quick   = 1'b1;
         end
         sts_pkg::MODE_QPNUM: begin
            do_pnum = 1'b1;
            reading = 1'b1;
            quick   = 1'b1;
         end
         sts_pkg::MODE_QPSKIP: begin
            do_pnum = 1'b1;
            quick   = 1'b1;
         end
         default: do_text = 1'b1;
      endcase

      // bracketed scope number
      if (do_pnum) begin
         if (c == sts_pkg::CH_RBRACKET) begin
            scope_in = pend_in;
            mode_in  = quick ? sts_pkg::MODE_QUICK : sts_pkg::MODE_TEXT;
            if (quick) qcm_in = sts_pkg::QCM_IDLE;
         end else if (reading && sts_pkg::is_digit(c)) begin
            if (pend_in == sts_pkg::SCOPE_FIRST) pend_in = sts_pkg::digit_scope(c);
            else pend_in = sts_pkg::SCOPE_OTHER;
         end else begin
            mode_in = quick ? sts_pkg::MODE_QPSKIP : sts_pkg::MODE_PSKIP;
         end
      end

      // tag letter after backslash and underscores
      if (do_tag) begin
         if (sts_pkg::is_tag_letter(c)) begin
            if (c == sts_pkg::CH_LOWER_Q && usc_in == 2'd1) begin
               mode_in = sts_pkg::MODE_QUICK;
               qcm_in  = sts_pkg::QCM_IDLE;
            end else begin
               mode_in = sts_pkg::MODE_AFTER;
               dtf_in  = (c == sts_pkg::CH_LOWER_W || c == sts_pkg::CH_LOWER_S);
            end
         end else begin
            do_text = 1'b1;
         end
         usc_in = 2'd0;
      end

      // character after backslash p
      if (do_psel) begin
         if (sts_pkg::is_digit(c)) begin
            scope_in = sts_pkg::digit_scope(c);
            mode_in  = quick ? sts_pkg::MODE_QUICK : sts_pkg::MODE_TEXT;
            if (quick) qcm_in = sts_pkg::QCM_IDLE;
         end else if (c == sts_pkg::CH_LBRACKET) begin
            pend_in = sts_pkg::SCOPE_FIRST;
            mode_in = quick ? sts_pkg::MODE_QPNUM : sts_pkg::MODE_PNUM;
         end else begin
            scope_in = sts_pkg::SCOPE_FIRST;
            if (quick) begin
               qcm_in   = sts_pkg::QCM_IDLE;
               do_quick = 1'b1;
            end else begin
               do_text = 1'b1;
            end
         end
      end

      // quick section character
      if (do_quick) begin
         mode_in = sts_pkg::MODE_QUICK;
         case (qcm_in)
            sts_pkg::QCM_IDLE: begin
               if (c == sts_pkg::CH_BACKSLASH) qcm_in = sts_pkg::QCM_BSL;
            end
            sts_pkg::QCM_BSL: begin
               qcm_in = sts_pkg::QCM_IDLE;
               if (c == sts_pkg::CH_UNDERSCORE) begin
                  qcm_in = sts_pkg::QCM_USC;
               end else if (c == sts_pkg::CH_ZERO || c == sts_pkg::CH_LOWER_H ||
                            c == sts_pkg::CH_ONE  || c == sts_pkg::CH_LOWER_U ||
                            c == sts_pkg::CH_LOWER_P) begin
                  if (seg_text_in) begin
                     body_vld = 1'b1;
                     body_res = sts_pkg::make_result(sts_pkg::KIND_END, '0,
                                   sts_pkg::voice_of(voice_set, scope_in));
                  end
                  seg_text_in = 1'b0;
                  if (c == sts_pkg::CH_LOWER_P) begin
                     mode_in = sts_pkg::MODE_QPSEL;
                  end else begin
                     scope_in = (c == sts_pkg::CH_ONE || c == sts_pkg::CH_LOWER_U) ?
                                sts_pkg::SCOPE_SECOND : sts_pkg::SCOPE_FIRST;
                  end
               end
            end
            default: begin
               qcm_in = sts_pkg::QCM_IDLE;
               if (c == sts_pkg::CH_LOWER_Q) mode_in = sts_pkg::MODE_TEXT;
               else if (c == sts_pkg::CH_BACKSLASH) qcm_in = sts_pkg::QCM_BSL;
            end
         endcase
      end

      // plain text character
      if (do_text) begin
         if (c == sts_pkg::CH_BACKSLASH) begin
            mode_in = sts_pkg::MODE_BSL;
         end else begin
            mode_in     = sts_pkg::MODE_TEXT;
            body_vld    = 1'b1;
            body_res    = sts_pkg::make_result(sts_pkg::KIND_TEXT, c,
                             sts_pkg::voice_of(voice_set, scope_in));
            seg_text_in = 1'b1;
         end
      end

      // end of script: close the segment and return to reset
      if (in_eos_ff) begin
         if (seg_text_in) begin
            eos_vld = 1'b1;
            eos_res = sts_pkg::make_result(sts_pkg::KIND_END, '0,
                         sts_pkg::voice_of(voice_set, scope_in));
         end
         mode_in     = sts_pkg::MODE_TEXT;
         usc_in      = 2'd0;
         dtf_in      = 1'b0;
         qcm_in      = sts_pkg::QCM_IDLE;
         scope_in    = sts_pkg::SCOPE_FIRST;
         pend_in     = sts_pkg::SCOPE_FIRST;
         seg_text_in = 1'b0;
      end
   end

   // pack results into queue slots in order
   always_comb begin
      push.push0 = step_fire & (body_vld | eos_vld);
      push.push1 = step_fire & body_vld & eos_vld;
      push.res0  = body_vld ? body_res : eos_res;
      push.res0.last_of_run = ~(body_vld & eos_vld);
      push.res1  = eos_res;
      push.res1.last_of_run = 1'b1;
   end

endmodule

FILE: hdl/sts_outq.sv
module sts_outq #(
   parameter int DEPTH = sts_pkg::OUTQ_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  sts_pkg::push_type push,
   output logic              room,
   sts_rsp_if.source         rsp
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sts_pkg::result_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in, wr_next;
   logic [PTR_W-1:0]     rd_ff, rd_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // room for a full step of two results
   assign room    = cnt_ff <= CNT_W'(DEPTH - 2);
   assign pop     = rsp.valid & rsp.ready;
   assign wr_next = ptr_inc(wr_ff);

   // pointer and count update
   always_comb begin
      wr_in  = push.push1 ? ptr_inc(wr_next) : (push.push0 ? wr_next : wr_ff);
      rd_in  = pop ? ptr_inc(rd_ff) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push.push0) mem_ff[wr_ff]   <= push.res0;
      if (push.push1) mem_ff[wr_next] <= push.res1;
   end

   // head item drives the result channel
   assign rsp.valid       = cnt_ff != '0;
   assign rsp.kind        = mem_ff[rd_ff].kind;
   assign rsp.text_char   = mem_ff[rd_ff].text_char;
   assign rsp.voice       = mem_ff[rd_ff].voice;
   assign rsp.last_of_run = mem_ff[rd_ff].last_of_run;

endmodule

FILE: hdl/script_tag_stripper_scope_split_unit.sv
// Script tag stripper with speaker scope split.
// An accepted item waits in the input register until the queue has room; its results
// then go to the result queue. Throughput: one item per cycle while the queue has room;
// an item with two results (text plus end of script) leaves the queue one at a time.
// Reset (synchronous, active high) clears parser state, queue and voice_set to 0.
module script_tag_stripper_scope_split_unit #(
   parameter int OUTQ_DEPTH = sts_pkg::OUTQ_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   sts_req_if.sink                     req_chan,
   sts_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [sts_pkg::VSET_W-1:0]  csr_wr_data
);

   logic [sts_pkg::VSET_W-1:0] voice_set_ff;
   logic                       room;
   sts_pkg::push_type          push;

   // voice set register
   always_ff @(posedge clock) begin
      if (reset) begin
         voice_set_ff <= '0;
      end else if (csr_wr_en) begin
         voice_set_ff <= csr_wr_data;
      end
   end

   sts_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .voice_set (voice_set_ff),
      .room      (room),
      .push      (push)
   );

   sts_outq #(
      .DEPTH (OUTQ_DEPTH)
   ) u_outq (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp_chan)
   );

   // second slot only filled together with the first
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0)
      else $error("second result pushed without first");

   // the second result of a step is always the closing end marker
   a_second_is_end: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> (push.res1.kind == sts_pkg::KIND_END) && push.res1.last_of_run
                     && !push.res0.last_of_run)
      else $error("bad two-result step");

   // a single result closes its run
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (push.push0 && !push.push1) |-> push.res0.last_of_run)
      else $error("single result not marked last");

   // end markers carry no character
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (push.push0 && push.res0.kind == sts_pkg::KIND_END) |-> push.res0.text_char == '0)
      else $error("end marker with character");

endmodule

FILE: bench/script_tag_stripper_scope_split_unit_tb.sv
module script_tag_stripper_scope_split_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [sts_pkg::VSET_W-1:0] VSET_MACHINE = 2'd2;
   localparam logic [sts_pkg::VSET_W-1:0] VSET_SPARE   = 2'd3;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 60;
   localparam int LIMIT_CYCLES = 200000;
   localparam int PHASE_ITEMS  = 100;

   typedef struct packed {
      logic [sts_pkg::CHAR_W-1:0] code;
      logic                       eos;
   } script_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                       csr_wr_en;
   logic [sts_pkg::VSET_W-1:0] csr_wr_data;

   sts_req_if req_chan ();
   sts_rsp_if rsp_chan ();

   script_tag_stripper_scope_split_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // stimulus and scoreboard storage
   script_item_type     script_q[$];
   sts_pkg::result_type expected_text_q[$];
   sts_pkg::result_type step_results[$];
   int items_queued   = 0;
   int items_accepted = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   // idle control, set per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_armed    = 1'b0;
   bit hold_done     = 1'b0;
   int hold_left     = 0;

   // predictor state
   logic [sts_pkg::VSET_W-1:0]  voice_family;
   sts_pkg::mode_type           scan_mode;
   logic [1:0]                  usc_count;
   logic                        ws_digit_ok;
   logic [1:0]                  qclose_step;
   logic [sts_pkg::SCOPE_W-1:0] cur_scope;
   logic [sts_pkg::SCOPE_W-1:0] scope_accum;
   logic                        seg_has_text;

   always #5ns clock = ~clock;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic logic is_dec(input logic [sts_pkg::CHAR_W-1:0] c);
      return c >= sts_pkg::CH_ZERO && c <= sts_pkg::CH_NINE;
   endfunction

   function automatic logic is_tag_char(input logic [sts_pkg::CHAR_W-1:0] c);
      if (is_dec(c) || c == sts_pkg::CH_BANG || c == sts_pkg::CH_QMARK) return 1'b1;
      if (c >= sts_pkg::CH_UPPER_A && c <= sts_pkg::CH_UPPER_Z) return 1'b1;
      return c >= sts_pkg::CH_LOWER_A && c <= sts_pkg::CH_LOWER_Z;
   endfunction

   // digits 2..9 all map to the catch-all scope
   function automatic logic [sts_pkg::SCOPE_W-1:0] dec_to_scope(
         input logic [sts_pkg::CHAR_W-1:0] c);
      logic [sts_pkg::CHAR_W-1:0] d;
      d = c - sts_pkg::CH_ZERO;
      if (d >= 2) return sts_pkg::SCOPE_OTHER;
      return d[sts_pkg::SCOPE_W-1:0];
   endfunction

   // voice set 3 behaves as the machine family
   function automatic logic [sts_pkg::VOICE_W-1:0] speaker_voice(
         input logic [sts_pkg::SCOPE_W-1:0] seg);
      logic [sts_pkg::VSET_W-1:0] fam;
      fam = (voice_family > VSET_MACHINE) ? VSET_MACHINE : voice_family;
      if (seg == sts_pkg::SCOPE_FIRST) begin
         case (fam)
            sts_pkg::VSET_FEMALE: return sts_pkg::VOICE_F0;
            sts_pkg::VSET_MALE:   return sts_pkg::VOICE_M0;
            default:              return sts_pkg::VOICE_X0;
         endcase
      end
      if (seg == sts_pkg::SCOPE_SECOND) begin
         case (fam)
            sts_pkg::VSET_FEMALE: return sts_pkg::VOICE_F1;
            sts_pkg::VSET_MALE:   return sts_pkg::VOICE_M1;
            default:              return sts_pkg::VOICE_X1;
         endcase
      end
      return sts_pkg::VOICE_OTHER;
   endfunction

   task automatic add_result(input logic k, input logic [sts_pkg::CHAR_W-1:0] ch);
      sts_pkg::result_type r;
      r.kind        = k;
      r.text_char   = ch;
      r.voice       = speaker_voice(cur_scope);
      r.last_of_run = 1'b0;
      if (step_results.size() < 2) step_results = {step_results, r};
   endtask

   task automatic close_segment();
      if (seg_has_text) add_result(sts_pkg::KIND_END, '0);
      seg_has_text = 1'b0;
   endtask

   task automatic take_text(input logic [sts_pkg::CHAR_W-1:0] c);
      scan_mode = sts_pkg::MODE_TEXT;
      if (c == sts_pkg::CH_BACKSLASH) begin
         scan_mode = sts_pkg::MODE_BSL;
      end else begin
         add_result(sts_pkg::KIND_TEXT, c);
         seg_has_text = 1'b1;
      end
   endtask

   // inside a quick section only scope tags and the closing tag matter
   task automatic take_quick(input logic [sts_pkg::CHAR_W-1:0] c);
      scan_mode = sts_pkg::MODE_QUICK;
      if (qclose_step == sts_pkg::QCM_IDLE) begin
         if (c == sts_pkg::CH_BACKSLASH) qclose_step = sts_pkg::QCM_BSL;
      end else if (qclose_step == sts_pkg::QCM_BSL) begin
         qclose_step = sts_pkg::QCM_IDLE;
         if (c == sts_pkg::CH_UNDERSCORE) begin
            qclose_step = sts_pkg::QCM_USC;
         end else if (c == sts_pkg::CH_ZERO || c == sts_pkg::CH_LOWER_H) begin
            close_segment();
            cur_scope = sts_pkg::SCOPE_FIRST;
         end else if (c == sts_pkg::CH_ONE || c == sts_pkg::CH_LOWER_U) begin
            close_segment();
            cur_scope = sts_pkg::SCOPE_SECOND;
         end else if (c == sts_pkg::CH_LOWER_P) begin
            close_segment();
            scan_mode = sts_pkg::MODE_QPSEL;
         end
      end else begin
         qclose_step = sts_pkg::QCM_IDLE;
         if (c == sts_pkg::CH_LOWER_Q) scan_mode = sts_pkg::MODE_TEXT;
         else if (c == sts_pkg::CH_BACKSLASH) qclose_step = sts_pkg::QCM_BSL;
      end
   endtask

   task automatic take_tag_letter(input logic [sts_pkg::CHAR_W-1:0] c);
      if (is_tag_char(c)) begin
         if (c == sts_pkg::CH_LOWER_Q && usc_count == 2'd1) begin
            scan_mode   = sts_pkg::MODE_QUICK;
            qclose_step = sts_pkg::QCM_IDLE;
         end else begin
            scan_mode   = sts_pkg::MODE_AFTER;
            ws_digit_ok = (c == sts_pkg::CH_LOWER_W || c == sts_pkg::CH_LOWER_S);
         end
         usc_count = 2'd0;
      end else begin
         usc_count = 2'd0;
         take_text(c);
      end
   endtask

   // character after backslash p
   task automatic pick_scope(input logic [sts_pkg::CHAR_W-1:0] c, input logic quick);
      if (is_dec(c)) begin
         cur_scope = dec_to_scope(c);
         scan_mode = quick ? sts_pkg::MODE_QUICK : sts_pkg::MODE_TEXT;
         if (quick) qclose_step = sts_pkg::QCM_IDLE;
      end else if (c == sts_pkg::CH_LBRACKET) begin
         scope_accum = sts_pkg::SCOPE_FIRST;
         scan_mode   = quick ? sts_pkg::MODE_QPNUM : sts_pkg::MODE_PNUM;
      end else begin
         cur_scope = sts_pkg::SCOPE_FIRST;
         if (quick) begin
            qclose_step = sts_pkg::QCM_IDLE;
            take_quick(c);
         end else begin
            take_text(c);
         end
      end
   endtask

   // bracketed scope number, digits read only before any other character
   task automatic read_scope_number(input logic [sts_pkg::CHAR_W-1:0] c,
                                    input logic quick, input logic reading);
      if (c == sts_pkg::CH_RBRACKET) begin
         cur_scope = scope_accum;
         scan_mode = quick ? sts_pkg::MODE_QUICK : sts_pkg::MODE_TEXT;
         if (quick) qclose_step = sts_pkg::QCM_IDLE;
      end else if (reading && is_dec(c)) begin
         if (scope_accum == sts_pkg::SCOPE_FIRST) scope_accum = dec_to_scope(c);
         else scope_accum = sts_pkg::SCOPE_OTHER;
      end else begin
         scan_mode = quick ? sts_pkg::MODE_QPSKIP : sts_pkg::MODE_PSKIP;
      end
   endtask

   task automatic clear_parser();
      scan_mode    = sts_pkg::MODE_TEXT;
      usc_count    = 2'd0;
      ws_digit_ok  = 1'b0;
      qclose_step  = sts_pkg::QCM_IDLE;
      cur_scope    = sts_pkg::SCOPE_FIRST;
      scope_accum  = sts_pkg::SCOPE_FIRST;
      seg_has_text = 1'b0;
   endtask

   task automatic predict_stripped_text(input logic [sts_pkg::CHAR_W-1:0] c,
                                        input logic eos);
      step_results.delete();
      case (scan_mode)
         sts_pkg::MODE_TEXT: take_text(c);
         sts_pkg::MODE_BSL: begin
            if (c == sts_pkg::CH_BACKSLASH) begin
               add_result(sts_pkg::KIND_TEXT, c);
               seg_has_text = 1'b1;
               scan_mode    = sts_pkg::MODE_TEXT;
            end else if (c == sts_pkg::CH_ZERO || c == sts_pkg::CH_LOWER_H) begin
               close_segment();
               cur_scope = sts_pkg::SCOPE_FIRST;
               scan_mode = sts_pkg::MODE_TEXT;
            end else if (c == sts_pkg::CH_ONE || c == sts_pkg::CH_LOWER_U) begin
               close_segment();
               cur_scope = sts_pkg::SCOPE_SECOND;
               scan_mode = sts_pkg::MODE_TEXT;
            end else if (c == sts_pkg::CH_LOWER_P) begin
               close_segment();
               scan_mode = sts_pkg::MODE_PSEL;
            end else if (c == sts_pkg::CH_UNDERSCORE) begin
               usc_count = 2'd1;
               scan_mode = sts_pkg::MODE_USC;
            end else begin
               usc_count = 2'd0;
               take_tag_letter(c);
            end
         end
         sts_pkg::MODE_USC: begin
            if (c == sts_pkg::CH_UNDERSCORE) begin
               if (usc_count < 2'd2) usc_count = usc_count + 2'd1;
            end else begin
               take_tag_letter(c);
            end
         end
         sts_pkg::MODE_AFTER: begin
            if (c == sts_pkg::CH_LBRACKET) scan_mode = sts_pkg::MODE_BRK;
            else if (is_dec(c) && ws_digit_ok) scan_mode = sts_pkg::MODE_TEXT;
            else take_text(c);
            ws_digit_ok = 1'b0;
         end
         sts_pkg::MODE_BRK: begin
            if (c == sts_pkg::CH_QUOTE) scan_mode = sts_pkg::MODE_BQUO;
            else if (c == sts_pkg::CH_RBRACKET) scan_mode = sts_pkg::MODE_TEXT;
         end
         sts_pkg::MODE_BQUO: begin
            if (c == sts_pkg::CH_QUOTE) scan_mode = sts_pkg::MODE_BRK;
         end
         sts_pkg::MODE_PSEL:   pick_scope(c, 1'b0);
         sts_pkg::MODE_PNUM:   read_scope_number(c, 1'b0, 1'b1);
         sts_pkg::MODE_PSKIP:  read_scope_number(c, 1'b0, 1'b0);
         sts_pkg::MODE_QUICK:  take_quick(c);
         sts_pkg::MODE_QPSEL:  pick_scope(c, 1'b1);
         sts_pkg::MODE_QPNUM:  read_scope_number(c, 1'b1, 1'b1);
         sts_pkg::MODE_QPSKIP: read_scope_number(c, 1'b1, 1'b0);
         default:              take_text(c);
      endcase

      // end of script flushes the segment and clears the parser
      if (eos) begin
         close_segment();
         clear_parser();
      end

      if (step_results.size() != 0) step_results[step_results.size()-1].last_of_run = 1'b1;
      foreach (step_results[i]) expected_text_q = {expected_text_q, step_results[i]};
   endtask

   // ---------------------------------------------------------------
   // stimulus generation
   // ---------------------------------------------------------------
   task automatic push_char(input logic [sts_pkg::CHAR_W-1:0] c);
      script_item_type it;
      it.code = c;
      it.eos  = 1'b0;
      script_q = {script_q, it};
      items_queued++;
   endtask

   function automatic logic [sts_pkg::CHAR_W-1:0] rand_plain();
      logic [sts_pkg::CHAR_W-1:0] c;
      if ($urandom_range(9) == 0) begin
         c = sts_pkg::CHAR_W'($urandom_range(16'hFFFF));
      end else begin
         c = sts_pkg::CHAR_W'($urandom_range(16'h7E, 16'h20));
         if (c == sts_pkg::CH_BACKSLASH) c = sts_pkg::CH_LOWER_A;
      end
      return c;
   endfunction

   function automatic logic [sts_pkg::CHAR_W-1:0] rand_digit();
      return sts_pkg::CH_ZERO + sts_pkg::CHAR_W'($urandom_range(9));
   endfunction

   function automatic logic [sts_pkg::CHAR_W-1:0] rand_tag_letter();
      case ($urandom_range(6))
         0:       return sts_pkg::CH_LOWER_W;
         1:       return sts_pkg::CH_LOWER_S;
         2:       return sts_pkg::CH_LOWER_A + sts_pkg::CHAR_W'($urandom_range(25));
         3:       return sts_pkg::CH_UPPER_A + sts_pkg::CHAR_W'($urandom_range(25));
         4:       return rand_digit();
         5:       return sts_pkg::CH_BANG;
         default: return sts_pkg::CH_QMARK;
      endcase
   endfunction

   function automatic logic [sts_pkg::CHAR_W-1:0] rand_special();
      case ($urandom_range(12))
         0:       return sts_pkg::CH_BACKSLASH;
         1:       return sts_pkg::CH_UNDERSCORE;
         2:       return sts_pkg::CH_LBRACKET;
         3:       return sts_pkg::CH_RBRACKET;
         4:       return sts_pkg::CH_QUOTE;
         5:       return sts_pkg::CH_LOWER_P;
         6:       return sts_pkg::CH_LOWER_Q;
         7:       return sts_pkg::CH_ZERO;
         8:       return sts_pkg::CH_ONE;
         9:       return sts_pkg::CH_NINE;
         10:      return sts_pkg::CH_LOWER_W;
         11:      return sts_pkg::CH_LOWER_S;
         default: return sts_pkg::CHAR_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic logic [sts_pkg::CHAR_W-1:0] rand_scope_char();
      case ($urandom_range(3))
         0:       return sts_pkg::CH_ZERO;
         1:       return sts_pkg::CH_ONE;
         2:       return sts_pkg::CH_LOWER_H;
         default: return sts_pkg::CH_LOWER_U;
      endcase
   endfunction

   // bracket parameter with quotes and would-be scope tags inside
   task automatic add_bracket_param();
      int n;
      n = $urandom_range(4);
      push_char(sts_pkg::CH_LBRACKET);
      repeat (n) begin
         case ($urandom_range(4))
            0: push_char(rand_plain());
            1: begin
               push_char(sts_pkg::CH_QUOTE);
               push_char(sts_pkg::CH_RBRACKET);
               push_char(sts_pkg::CH_QUOTE);
            end
            2: begin
               push_char(sts_pkg::CH_BACKSLASH);
               push_char(rand_scope_char());
            end
            3: push_char(rand_digit());
            default: push_char(sts_pkg::CH_QUOTE);
         endcase
      end
      if ($urandom_range(9) != 0) push_char(sts_pkg::CH_RBRACKET);
   endtask

   // backslash p with a digit, a bracketed number or neither
   task automatic add_scope_select();
      int n;
      n = $urandom_range(3);
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_LOWER_P);
      case ($urandom_range(3))
         0: push_char(rand_digit());
         1, 2: begin
            push_char(sts_pkg::CH_LBRACKET);
            repeat (n) push_char(rand_digit());
            if ($urandom_range(3) == 0) push_char(rand_plain());
            push_char(sts_pkg::CH_RBRACKET);
         end
         default: push_char(rand_plain());
      endcase
   endtask

   task automatic add_quick_section();
      int n;
      n = $urandom_range(6);
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_UNDERSCORE);
      push_char(sts_pkg::CH_LOWER_Q);
      repeat (n) begin
         case ($urandom_range(3))
            0: push_char(rand_plain());
            1: begin
               push_char(sts_pkg::CH_BACKSLASH);
               push_char(rand_scope_char());
            end
            2: add_scope_select();
            default: begin
               push_char(sts_pkg::CH_BACKSLASH);
               push_char(sts_pkg::CH_BACKSLASH);
            end
         endcase
      end
      if ($urandom_range(9) != 0) begin
         push_char(sts_pkg::CH_BACKSLASH);
         push_char(sts_pkg::CH_UNDERSCORE);
         push_char(sts_pkg::CH_LOWER_Q);
      end
   endtask

   task automatic add_markup_token();
      int r;
      int n;
      r = $urandom_range(99);
      n = $urandom_range(3);
      if (r < 40) begin
         push_char(rand_plain());
      end else if (r < 50) begin
         push_char(sts_pkg::CH_BACKSLASH);
         push_char(rand_scope_char());
      end else if (r < 58) begin
         add_scope_select();
      end else if (r < 72) begin
         // removed tag: underscores, letter, optional digit or parameter
         push_char(sts_pkg::CH_BACKSLASH);
         repeat (n) push_char(sts_pkg::CH_UNDERSCORE);
         push_char(rand_tag_letter());
         case ($urandom_range(2))
            0: ;
            1: push_char(rand_digit());
            default: add_bracket_param();
         endcase
      end else if (r < 78) begin
         push_char(sts_pkg::CH_BACKSLASH);
         push_char(sts_pkg::CH_BACKSLASH);
      end else if (r < 86) begin
         add_quick_section();
      end else begin
         push_char(rand_special());
      end
   endtask

   task automatic gen_script(input int len);
      int start;
      start = items_queued;
      while (items_queued - start < len) add_markup_token();
      script_q[script_q.size()-1].eos = 1'b1;
   endtask

   task automatic add_directed_script();
      push_char(16'h0000);
      push_char(16'hFFFF);
      // escape, then a scope switch that closes a non-empty segment
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_LOWER_U);
      push_char(sts_pkg::CH_LOWER_A);
      // scope above one
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_LOWER_P);
      push_char(sts_pkg::CH_ZERO + 16'd5);
      push_char(sts_pkg::CH_UPPER_Z);
      // backslash p with neither digit nor bracket
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_LOWER_P);
      push_char(sts_pkg::CH_UPPER_A);
      // scope tag inside a bracket parameter is ignored
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_BANG);
      push_char(sts_pkg::CH_LBRACKET);
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_ONE);
      push_char(sts_pkg::CH_RBRACKET);
      // non-letter after tag start is kept
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_UNDERSCORE);
      push_char(sts_pkg::CH_QUOTE);
      // unclosed quick section with a scope tag inside
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_UNDERSCORE);
      push_char(sts_pkg::CH_LOWER_Q);
      push_char(sts_pkg::CH_BACKSLASH);
      push_char(sts_pkg::CH_ONE);
      push_char(sts_pkg::CH_NINE);
      script_q[script_q.size()-1].eos = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // phase control
   // ---------------------------------------------------------------
   task automatic wait_drained();
      while (items_accepted != items_queued || expected_text_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_voice_set(input logic [sts_pkg::VSET_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      voice_family = v;
   endtask

   task automatic run_phase(input logic [sts_pkg::VSET_W-1:0] v, input int send_pct,
                            input int recv_pct, input bit hold);
      int start;
      wait_drained();
      write_voice_set(v);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS) gen_script($urandom_range(30, 4));
      if (hold) hold_armed = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      voice_family = sts_pkg::VSET_FEMALE;
      clear_parser();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed script under the spare voice set
      send_idle_pct = 34;
      recv_idle_pct = 81;
      write_voice_set(VSET_SPARE);
      add_directed_script();

      run_phase(sts_pkg::VSET_FEMALE, 34, 81, 1'b0);
      run_phase(sts_pkg::VSET_MALE,   81, 34, 1'b0);
      run_phase(VSET_MACHINE,          0,  0, 1'b1);
      run_phase(VSET_SPARE,            0,  0, 1'b0);
      wait_drained();

      if (expected_text_q.size() != 0) begin
         $error("%0d expected result items never arrived", expected_text_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // driver: offers queued items, predicts on acceptance
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      script_item_type nxt;
      if (reset) begin
         req_chan.valid         <= 1'b0;
         req_chan.char_code     <= '0;
         req_chan.end_of_script <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_stripped_text(req_chan.char_code, req_chan.end_of_script);
            items_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (script_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = script_q[0];
               script_q.delete(0);
               req_chan.valid         <= 1'b1;
               req_chan.char_code     <= nxt.code;
               req_chan.end_of_script <= nxt.eos;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: random stalls plus one long hold-off
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: compare each accepted result with the oldest expectation
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      sts_pkg::result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_text_q.size() == 0) begin
            $error("unexpected result item: kind %0d text_char %0d voice %0d",
                   rsp_chan.kind, rsp_chan.text_char, rsp_chan.voice);
            error_count++;
         end else begin
            want = expected_text_q[0];
            expected_text_q.delete(0);
            check_field("kind", int'(want.kind), int'(rsp_chan.kind));
            check_field("text_char", int'(want.text_char), int'(rsp_chan.text_char));
            check_field("voice", int'(want.voice), int'(rsp_chan.voice));
            check_field("last_of_run", int'(want.last_of_run),
                        int'(rsp_chan.last_of_run));
         end
      end
   end

endmodule
